// ----- hdl/mcrlm_pkg.sv -----
// Shared types and constants for the microphone capture ring and level meter.
`default_nettype none

package mcrlm_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam int CONV_SHIFT = 8;
  localparam int SAMPLE_W   = 16;

  typedef struct packed {
    logic               command;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic               last_in_block;
    logic [15:0]        read_count;
    logic [15:0]        read_index;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] audio_sample;
    logic [9:0]         valid_count;
    logic [31:0]        level;
  } rsp_beat_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_READ,
    KIND_INVALID,
    KIND_NOT_READY
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SAMPLE_W-1:0]   mono;
    logic [31:0]           mag;
    logic                  last;
    logic [15:0]           read_count;
    logic [15:0]           read_index;
  } job_t;

endpackage

`default_nettype wire

// ----- hdl/mcrlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mcrlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mcrlm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the block mean.
`default_nettype none

module mcrlm_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign done     = busy && (cnt == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
        quo <= {quo[DVD_W-2:0], fits};
        rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mcrlm_front.sv -----
// Front end: accepts request beats, classifies them and queues jobs.
`default_nettype none

module mcrlm_front
  import mcrlm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_beat_t req,
  output logic           job_valid,
  input  wire logic      job_take,
  output job_t           job
);

  logic        capture_enabled;
  logic        wr_sel;
  logic        rd_sel;
  logic [1:0]  fill;
  job_t        slot [2];
  job_t        job_in;
  logic [31:0] left_u;
  logic [31:0] right_u;
  logic [31:0] left_mag;
  logic [31:0] right_mag;
  logic [31:0] mono;
  logic        push;

  always_comb begin
    left_u    = req.left_sample;
    right_u   = req.right_sample;
    left_mag  = left_u[31] ? (32'd0 - left_u) : left_u;
    right_mag = right_u[31] ? (32'd0 - right_u) : right_u;
    mono      = (left_u == '0 && right_u != '0) ? right_u : left_u;

    job_in.mono       = mono[CONV_SHIFT +: SAMPLE_W];
    job_in.mag        = (left_mag > right_mag) ? left_mag : right_mag;
    job_in.last       = req.last_in_block;
    job_in.read_count = req.read_count;
    job_in.read_index = req.read_index;
    if (!req.command) begin
      job_in.kind = KIND_SAMPLE;
    end else if (req.read_count == '0 || req.read_index >= req.read_count) begin
      job_in.kind = KIND_INVALID;
    end else if (!capture_enabled) begin
      job_in.kind = KIND_NOT_READY;
    end else begin
      job_in.kind = KIND_READ;
    end
  end

  assign req_ready = fill != 2'd2;
  assign push      = req_valid && req_ready;
  assign job_valid = fill != 2'd0;
  assign job       = slot[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enabled <= 1'b0;
      wr_sel          <= 1'b0;
      rd_sel          <= 1'b0;
      fill            <= 2'd0;
    end else begin
      if (cfg_we) begin
        capture_enabled <= cfg_data;
      end
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (job_take) begin
        rd_sel <= ~rd_sel;
      end
      case ({push, job_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= job_in;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mcrlm_back.sv -----
// Back end: ring writes and reads, block sums, mean division and response register.
`default_nettype none

module mcrlm_back
  import mcrlm_pkg::*;
#(
  parameter int WINDOW    = 512,
  parameter int MAX_BLOCK = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_take,
  input  wire job_t job,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_beat_t rsp
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int AW    = PTR_W + 1;
  localparam int SC_W  = $clog2(WINDOW + 1);
  localparam int CMP_W = (SC_W > 16) ? SC_W : 16;
  localparam int BC_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = 32 + BC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_ADDR,
    S_DATA,
    S_RESP
  } state_t;

  state_t              state;
  logic [PTR_W-1:0]    wp;
  logic [SC_W-1:0]     stored;
  logic [SUM_W-1:0]    sum;
  logic [BC_W-1:0]     bcount;
  logic [31:0]         level_value;
  logic [SC_W-1:0]     read_back;

  logic [PTR_W-1:0]    wp_next;
  logic [SUM_W-1:0]    sum_next;
  logic [BC_W-1:0]     bcount_next;
  logic                close;
  logic                is_sample;
  logic [CMP_W-1:0]    stored_ext;
  logic [CMP_W-1:0]    count_ext;
  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    copy;
  logic                hit;
  logic [SC_W-1:0]     back_next;
  logic [AW-1:0]       addr_sum;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;

  always_comb begin
    job_take    = (state == S_IDLE) && job_valid;
    is_sample   = job_take && (job.kind == KIND_SAMPLE);
    wp_next     = (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;
    sum_next    = sum + SUM_W'(job.mag);
    bcount_next = bcount + 1'b1;
    close       = job.last || (bcount_next >= BC_W'(MAX_BLOCK));

    stored_ext  = CMP_W'(stored);
    count_ext   = CMP_W'(job.read_count);
    idx_ext     = CMP_W'(job.read_index);
    copy        = (stored_ext < count_ext) ? stored_ext : count_ext;
    hit         = idx_ext < copy;
    back_next   = SC_W'(copy - idx_ext);

    addr_sum    = AW'(wp) + AW'(WINDOW) - AW'(read_back);
    rd_addr     = (addr_sum >= AW'(WINDOW)) ? PTR_W'(addr_sum - AW'(WINDOW))
                                            : PTR_W'(addr_sum);
    rsp_valid   = state == S_RESP;
  end

  mcrlm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (is_sample),
    .wr_addr (wp),
    .wr_data (job.mono),
    .rd_en   (state == S_ADDR),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mcrlm_div #(
    .DVD_W (SUM_W),
    .DVS_W (BC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (is_sample && close),
    .dividend (sum_next),
    .divisor  (bcount_next),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      stored      <= '0;
      sum         <= '0;
      bcount      <= '0;
      level_value <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_take) begin
            case (job.kind)
              KIND_SAMPLE: begin
                rsp.status       <= ST_OK;
                rsp.audio_sample <= '0;
                rsp.valid_count  <= '0;
                wp               <= wp_next;
                if (stored != SC_W'(WINDOW)) begin
                  stored <= stored + 1'b1;
                end
                if (close) begin
                  sum    <= '0;
                  bcount <= '0;
                  state  <= S_DIVIDE;
                end else begin
                  sum       <= sum_next;
                  bcount    <= bcount_next;
                  rsp.level <= level_value;
                  state     <= S_RESP;
                end
              end
              KIND_READ: begin
                rsp.status       <= ST_OK;
                rsp.audio_sample <= '0;
                rsp.valid_count  <= copy[9:0];
                rsp.level        <= level_value;
                read_back        <= back_next;
                state            <= hit ? S_ADDR : S_RESP;
              end
              KIND_INVALID: begin
                rsp.status       <= ST_INVALID;
                rsp.audio_sample <= '0;
                rsp.valid_count  <= '0;
                rsp.level        <= '0;
                state            <= S_RESP;
              end
              default: begin
                rsp.status       <= ST_NOT_READY;
                rsp.audio_sample <= '0;
                rsp.valid_count  <= '0;
                rsp.level        <= '0;
                state            <= S_RESP;
              end
            endcase
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            level_value <= quotient[31:0];
            rsp.level   <= quotient[31:0];
            state       <= S_RESP;
          end
        end
        S_ADDR: begin
          state <= S_DATA;
        end
        S_DATA: begin
          rsp.audio_sample <= rd_data;
          state            <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mic_capture_ring_level_meter_unit.sv -----
// Path from request to response: a sample beat goes from S_IDLE straight to S_RESP; one
// that closes a block waits in S_DIVIDE for the bit-serial mean divider; a read beat
// passes S_ADDR and S_DATA for a ring hit, else goes straight to S_RESP.
// Throughput: the back end runs one job at a time, taking no new job until its response
// is accepted; a two-entry job queue takes up to two more beats while a response waits.
// Reset (rst, synchronous): clears pointers, counts, block sum, level, enable and queue;
// ring contents are left as they are.
`default_nettype none

module mic_capture_ring_level_meter_unit
  import mcrlm_pkg::*;
#(
  parameter int WINDOW    = 512,
  parameter int MAX_BLOCK = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_beat_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_beat_t      rsp
);

  logic job_valid;
  logic job_take;
  job_t job;

  mcrlm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  mcrlm_back #(
    .WINDOW    (WINDOW),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- hdl/mcrlm_checker.sv -----
// Port-level assertions for the capture ring unit, bound to the top level.
`default_nettype none

module mcrlm_checker
  import mcrlm_pkg::*;
#(
  parameter int WINDOW = 512
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      rsp_valid,
  input wire logic      rsp_ready,
  input wire rsp_beat_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_INVALID || rsp.status == ST_NOT_READY) |->
      rsp.audio_sample == '0 && rsp.valid_count == '0 && rsp.level == '0)
    else $error("failed request carries nonzero payload");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_OK |-> (WINDOW >= 1024) || (rsp.valid_count <= WINDOW))
    else $error("valid count above ring size");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind mic_capture_ring_level_meter_unit mcrlm_checker #(.WINDOW(WINDOW)) u_checker (.*);

`default_nettype wire
